[sv/bps_pkg.sv]
// Package for the battery pack supervisor: payload structs, register indexes,
// state codes and fixed constants. It depends on nothing else.
package bps_pkg;

  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned CfgIdxW    = $clog2(NumCfgRegs);
  localparam int unsigned CfgDataW   = 13;

  localparam logic signed [8:0] WarnTempOffset = 9'sd5;

  localparam int unsigned AlarmOvBit = 2;
  localparam int unsigned AlarmUvBit = 4;
  localparam int unsigned AlarmOtBit = 6;

  localparam logic [7:0] InverterRun = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVER_VOLTAGE  = 3'd0,
    CFG_UNDER_VOLTAGE = 3'd1,
    CFG_BALANCE_START = 3'd2,
    CFG_BALANCE_HYST  = 3'd3,
    CFG_OVER_TEMP     = 3'd4,
    CFG_UNDER_TEMP    = 3'd5,
    CFG_CELL_GAP      = 3'd6,
    CFG_WARN_OFFSET   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PS_BOOT      = 3'd0,
    PS_READY     = 3'd1,
    PS_PRECHARGE = 3'd2,
    PS_DRIVE     = 3'd3,
    PS_CHARGE    = 3'd4,
    PS_ERROR     = 3'd5
  } pack_state_e;

  typedef enum logic [5:0] {
    MODE_BOOT      = 6'b000001,
    MODE_READY     = 6'b000010,
    MODE_PRECHARGE = 6'b000100,
    MODE_DRIVE     = 6'b001000,
    MODE_CHARGE    = 6'b010000,
    MODE_ERROR     = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [12:0]        over_voltage_mv;
    logic [12:0]        under_voltage_mv;
    logic [12:0]        balance_start_mv;
    logic [9:0]         balance_hyst_mv;
    logic signed [7:0]  over_temp_c;
    logic signed [7:0]  under_temp_c;
    logic [9:0]         cell_gap_mv;
    logic [9:0]         warn_volt_offset_mv;
  } cfg_t;

  typedef struct packed {
    logic [12:0]       high_cell_mv;
    logic [12:0]       low_cell_mv;
    logic signed [7:0] high_temp_c;
    logic signed [7:0] low_temp_c;
    logic              charge_enabled;
    logic              drive_enabled;
    logic [7:0]        inverter_status;
    logic              charge_done;
    logic              cell_count_ok;
    logic              fault;
  } in_t;

  typedef struct packed {
    logic [2:0] pack_state;
    logic       balance_active;
    logic [7:0] alarm_volt_temp;
    logic       alarm_low_temp;
    logic       alarm_imbalance;
    logic [7:0] warn_volt_temp;
    logic       warn_low_temp;
  } out_t;

endpackage

[sv/battery_pack_supervisor_top.sv]
// Battery pack supervisor: threshold alarms, warnings, pack state and balancing.
// Depends on bps_pkg for payload structs, register indexes and state codes.
//
//   channel  signals                                  direction  moves
//   in       in_valid_i, in_ready_o, in_data_i        to block   one tick word
//   out      out_valid_o, out_ready_i, out_data_o     from block one result word
//   cfg      cfg_valid_i, cfg_ready_o, cfg_index_i,   to block   one register word
//            cfg_data_i
//
// A word is captured in an input register and its result is then registered in the result
// register; one word is taken per cycle unless the result register is held.
// The pack state and balancing flag advance when a word moves into the result register.
// Reset loads the default thresholds and puts the pack in Boot; cfg is always ready.
// When the result register is held, a word in the input register holds and in_ready_o falls.
module battery_pack_supervisor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bps_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bps_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  bps_pkg::cfg_idx_e              cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bps_pkg::*;

  cfg_t  cfg_q;
  in_t   in_q;
  logic  in_valid_q;
  out_t  res_q, res_d;
  logic  res_valid_q;
  mode_e mode_q, mode_d;
  logic  bal_q, bal_d;
  logic  res_load;

  logic [13:0]        low_plus_hyst;
  logic [13:0]        uv_plus_woff;
  logic signed [14:0] ov_minus_woff;
  logic signed [13:0] spread;
  logic signed [8:0]  ot_warn;
  logic signed [8:0]  ut_warn;
  logic               closed;
  logic               chg;
  logic               drv;
  logic               high_over_bstart;
  logic [2:0]         state_code;

  assign cfg_ready_o = 1'b1;
  assign res_load    = in_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || res_load;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_voltage_mv     <= 13'd4200;
      cfg_q.under_voltage_mv    <= 13'd3000;
      cfg_q.balance_start_mv    <= 13'd3900;
      cfg_q.balance_hyst_mv     <= 10'd40;
      cfg_q.over_temp_c         <= 8'sd65;
      cfg_q.under_temp_c        <= -8'sd10;
      cfg_q.cell_gap_mv         <= 10'd200;
      cfg_q.warn_volt_offset_mv <= 10'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OVER_VOLTAGE:  cfg_q.over_voltage_mv     <= cfg_data_i;
        CFG_UNDER_VOLTAGE: cfg_q.under_voltage_mv    <= cfg_data_i;
        CFG_BALANCE_START: cfg_q.balance_start_mv    <= cfg_data_i;
        CFG_BALANCE_HYST:  cfg_q.balance_hyst_mv     <= cfg_data_i[9:0];
        CFG_OVER_TEMP:     cfg_q.over_temp_c         <= cfg_data_i[7:0];
        CFG_UNDER_TEMP:    cfg_q.under_temp_c        <= cfg_data_i[7:0];
        CFG_CELL_GAP:      cfg_q.cell_gap_mv         <= cfg_data_i[9:0];
        CFG_WARN_OFFSET:   cfg_q.warn_volt_offset_mv <= cfg_data_i[9:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      mode_q      <= MODE_BOOT;
      bal_q       <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
        mode_q      <= mode_d;
        bal_q       <= bal_d;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign low_plus_hyst    = {1'b0, in_q.low_cell_mv} + {4'd0, cfg_q.balance_hyst_mv};
  assign uv_plus_woff     = {1'b0, cfg_q.under_voltage_mv} + {4'd0, cfg_q.warn_volt_offset_mv};
  assign ov_minus_woff    = $signed({2'b00, cfg_q.over_voltage_mv})
                            - $signed({5'd0, cfg_q.warn_volt_offset_mv});
  assign spread           = $signed({1'b0, in_q.high_cell_mv})
                            - $signed({1'b0, in_q.low_cell_mv});
  assign ot_warn          = 9'(cfg_q.over_temp_c) - WarnTempOffset;
  assign ut_warn          = 9'(cfg_q.under_temp_c) + WarnTempOffset;
  assign closed           = in_q.inverter_status == InverterRun;
  assign chg              = in_q.charge_enabled;
  assign drv              = in_q.drive_enabled;
  assign high_over_bstart = in_q.high_cell_mv > cfg_q.balance_start_mv;

  always_comb begin
    mode_d = mode_q;
    bal_d  = bal_q;
    unique case (mode_q)
      MODE_BOOT: begin
        mode_d = MODE_READY;
      end
      MODE_READY: begin
        if (chg || drv) begin
          mode_d = MODE_PRECHARGE;
        end
        bal_d = high_over_bstart && ({1'b0, in_q.high_cell_mv} > low_plus_hyst);
      end
      MODE_PRECHARGE: begin
        priority if (chg && closed) begin
          mode_d = MODE_CHARGE;
        end else if (drv && closed) begin
          mode_d = MODE_DRIVE;
        end else begin
          mode_d = MODE_PRECHARGE;
        end
      end
      MODE_DRIVE: begin
        mode_d = MODE_DRIVE;
      end
      MODE_CHARGE: begin
        if (!chg || !closed || in_q.charge_done) begin
          mode_d = MODE_READY;
        end
        bal_d = high_over_bstart;
      end
      default: begin
        if ((in_q.low_cell_mv >= cfg_q.under_voltage_mv) && in_q.cell_count_ok) begin
          mode_d = MODE_READY;
        end
        bal_d = 1'b0;
      end
    endcase
    if (in_q.fault) begin
      mode_d = MODE_ERROR;
    end
  end

  always_comb begin
    unique case (mode_d)
      MODE_BOOT:      state_code = PS_BOOT;
      MODE_READY:     state_code = PS_READY;
      MODE_PRECHARGE: state_code = PS_PRECHARGE;
      MODE_DRIVE:     state_code = PS_DRIVE;
      MODE_CHARGE:    state_code = PS_CHARGE;
      default:        state_code = PS_ERROR;
    endcase
  end

  always_comb begin
    res_d                 = '0;
    res_d.pack_state      = state_code;
    res_d.balance_active  = bal_d;
    res_d.alarm_volt_temp[AlarmOvBit] = in_q.high_cell_mv > cfg_q.over_voltage_mv;
    res_d.alarm_volt_temp[AlarmUvBit] = in_q.low_cell_mv < cfg_q.under_voltage_mv;
    res_d.alarm_volt_temp[AlarmOtBit] = in_q.high_temp_c > cfg_q.over_temp_c;
    res_d.alarm_low_temp  = in_q.low_temp_c < cfg_q.under_temp_c;
    res_d.alarm_imbalance = spread > $signed({4'd0, cfg_q.cell_gap_mv});
    res_d.warn_volt_temp[AlarmOvBit] = $signed({2'b00, in_q.high_cell_mv}) > ov_minus_woff;
    res_d.warn_volt_temp[AlarmUvBit] = {1'b0, in_q.low_cell_mv} < uv_plus_woff;
    res_d.warn_volt_temp[AlarmOtBit] = 9'(in_q.high_temp_c) > ot_warn;
    res_d.warn_low_temp   = 9'(in_q.low_temp_c) < ut_warn;
  end

endmodule

[verif/tb.sv]
// Testbench for battery_pack_supervisor_top: a scoreboard class predicts every result word
// and the tb module drives tick and result channels with random idling, and the register channel without.
// Depends on bps_pkg and the battery_pack_supervisor_top RTL.
import bps_pkg::*;

class bps_scoreboard;
  cfg_t        cfg;
  pack_state_e mode;
  logic        balancing;
  out_t        expected_words[$];
  int          errors;

  function new();
    cfg.over_voltage_mv     = 13'd4200;
    cfg.under_voltage_mv    = 13'd3000;
    cfg.balance_start_mv    = 13'd3900;
    cfg.balance_hyst_mv     = 10'd40;
    cfg.over_temp_c         = 8'sd65;
    cfg.under_temp_c        = -8'sd10;
    cfg.cell_gap_mv         = 10'd200;
    cfg.warn_volt_offset_mv = 10'd100;
    mode      = PS_BOOT;
    balancing = 1'b0;
    errors    = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [12:0] d);
    case (idx)
      CFG_OVER_VOLTAGE:  cfg.over_voltage_mv     = d;
      CFG_UNDER_VOLTAGE: cfg.under_voltage_mv    = d;
      CFG_BALANCE_START: cfg.balance_start_mv    = d;
      CFG_BALANCE_HYST:  cfg.balance_hyst_mv     = d[9:0];
      CFG_OVER_TEMP:     cfg.over_temp_c         = d[7:0];
      CFG_UNDER_TEMP:    cfg.under_temp_c        = d[7:0];
      CFG_CELL_GAP:      cfg.cell_gap_mv         = d[9:0];
      CFG_WARN_OFFSET:   cfg.warn_volt_offset_mv = d[9:0];
      default: ;
    endcase
  endfunction

  function void note_tick(in_t w);
    int   hi, lo, ht, lt, ov, uv, bs, bh, ot, ut, gap, wo, toff;
    logic closed;
    out_t r;
    hi     = int'(w.high_cell_mv);
    lo     = int'(w.low_cell_mv);
    ht     = int'($signed(w.high_temp_c));
    lt     = int'($signed(w.low_temp_c));
    ov     = int'(cfg.over_voltage_mv);
    uv     = int'(cfg.under_voltage_mv);
    bs     = int'(cfg.balance_start_mv);
    bh     = int'(cfg.balance_hyst_mv);
    ot     = int'($signed(cfg.over_temp_c));
    ut     = int'($signed(cfg.under_temp_c));
    gap    = int'(cfg.cell_gap_mv);
    wo     = int'(cfg.warn_volt_offset_mv);
    toff   = int'(WarnTempOffset);
    closed = (w.inverter_status == InverterRun);
    r = '0;
    r.alarm_volt_temp[AlarmOvBit] = (hi > ov);
    r.alarm_volt_temp[AlarmUvBit] = (lo < uv);
    r.alarm_volt_temp[AlarmOtBit] = (ht > ot);
    r.alarm_low_temp              = (lt < ut);
    r.alarm_imbalance             = ((hi - lo) > gap);
    r.warn_volt_temp[AlarmOvBit]  = (hi > ov - wo);
    r.warn_volt_temp[AlarmUvBit]  = (lo < uv + wo);
    r.warn_volt_temp[AlarmOtBit]  = (ht > ot - toff);
    r.warn_low_temp               = (lt < ut + toff);
    case (mode)
      PS_BOOT: mode = PS_READY;
      PS_READY: begin
        if (w.charge_enabled || w.drive_enabled) mode = PS_PRECHARGE;
        balancing = (hi > bs) && (hi > lo + bh);
      end
      PS_PRECHARGE: begin
        if (w.charge_enabled && closed) mode = PS_CHARGE;
        else if (w.drive_enabled && closed) mode = PS_DRIVE;
      end
      PS_DRIVE: ;
      PS_CHARGE: begin
        if (!w.charge_enabled || !closed || w.charge_done) mode = PS_READY;
        balancing = (hi > bs);
      end
      default: begin
        if (lo >= uv && w.cell_count_ok) mode = PS_READY;
        balancing = 1'b0;
      end
    endcase
    if (w.fault) mode = PS_ERROR;
    r.pack_state     = mode;
    r.balance_active = balancing;
    expected_words.push_back(r);
  endfunction

  function void compare(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (expected_words.size() == 0) begin
      $error("result word arrived with no expectation pending");
      errors++;
      return;
    end
    want = expected_words.pop_front();
    compare("pack_state", 8'(want.pack_state), 8'(got.pack_state));
    compare("balance_active", 8'(want.balance_active), 8'(got.balance_active));
    compare("alarm_volt_temp", want.alarm_volt_temp, got.alarm_volt_temp);
    compare("alarm_low_temp", 8'(want.alarm_low_temp), 8'(got.alarm_low_temp));
    compare("alarm_imbalance", 8'(want.alarm_imbalance), 8'(got.alarm_imbalance));
    compare("warn_volt_temp", want.warn_volt_temp, got.warn_volt_temp);
    compare("warn_low_temp", 8'(want.warn_low_temp), 8'(got.warn_low_temp));
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseTicks    = 195;
  localparam int SetNominal    = 0;
  localparam int SetMax        = 1;
  localparam int SetMin        = 2;
  localparam int SetCrossed    = 3;
  localparam int SetRandom     = 4;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  in_t      in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_t     out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_e cfg_index_i = CFG_OVER_VOLTAGE;
  logic [12:0] cfg_data_i = '0;

  bps_scoreboard sb = new();
  bit stalls_on = 1'b1;
  int quiet_cycles = 0;

  battery_pack_supervisor_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= !stalls_on || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t mk(int hi, int lo, int ht, int lt, bit chg, bit drv, int inv,
                             bit done, bit ok, bit flt);
    in_t w;
    w.high_cell_mv    = hi[12:0];
    w.low_cell_mv     = lo[12:0];
    w.high_temp_c     = ht[7:0];
    w.low_temp_c      = lt[7:0];
    w.charge_enabled  = chg;
    w.drive_enabled   = drv;
    w.inverter_status = inv[7:0];
    w.charge_done     = done;
    w.cell_count_ok   = ok;
    w.fault           = flt;
    return w;
  endfunction

  function automatic int near_mv(int base);
    int v;
    v = base - 150 + int'($urandom_range(300));
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v;
  endfunction

  function automatic int near_c(int base);
    int v;
    v = base - 8 + int'($urandom_range(16));
    if (v < -128) v = -128;
    if (v > 127) v = 127;
    return v;
  endfunction

  function automatic in_t rand_tick();
    int hi, lo, ht, lt, ov, uv, wo, ot, ut, toff;
    ov   = int'(sb.cfg.over_voltage_mv);
    uv   = int'(sb.cfg.under_voltage_mv);
    wo   = int'(sb.cfg.warn_volt_offset_mv);
    ot   = int'($signed(sb.cfg.over_temp_c));
    ut   = int'($signed(sb.cfg.under_temp_c));
    toff = int'(WarnTempOffset);
    case ($urandom_range(3))
      0: hi = int'($urandom_range(8191));
      1: hi = near_mv(ov);
      2: hi = near_mv(ov - wo);
      default: hi = near_mv(int'(sb.cfg.balance_start_mv));
    endcase
    case ($urandom_range(4))
      0: lo = int'($urandom_range(8191));
      1: lo = near_mv(uv);
      2: lo = near_mv(uv + wo);
      3: lo = near_mv(hi - int'(sb.cfg.cell_gap_mv));
      default: lo = near_mv(hi - int'(sb.cfg.balance_hyst_mv));
    endcase
    case ($urandom_range(2))
      0: ht = int'($urandom_range(255));
      1: ht = near_c(ot);
      default: ht = near_c(ot - toff);
    endcase
    case ($urandom_range(2))
      0: lt = int'($urandom_range(255));
      1: lt = near_c(ut);
      default: lt = near_c(ut + toff);
    endcase
    return mk(hi, lo, ht, lt, $urandom_range(99) < 40, $urandom_range(99) < 40,
              ($urandom_range(99) < 60) ? int'(InverterRun) : int'($urandom_range(255)),
              $urandom_range(99) < 20, $urandom_range(99) < 85, $urandom_range(99) < 4);
  endfunction

  function automatic logic [12:0] cfg_value(int kind, cfg_idx_e idx);
    logic temp_reg;
    temp_reg = (idx == CFG_OVER_TEMP) || (idx == CFG_UNDER_TEMP);
    case (kind)
      SetMax: return temp_reg ? 13'h007F : 13'h1FFF;
      SetMin: return temp_reg ? 13'h0080 : 13'h0000;
      SetCrossed: begin
        case (idx)
          CFG_OVER_VOLTAGE:  return 13'h0000;
          CFG_UNDER_VOLTAGE: return 13'h1FFF;
          CFG_WARN_OFFSET:   return 13'h03FF;
          CFG_OVER_TEMP:     return 13'h0080;
          CFG_UNDER_TEMP:    return 13'h007F;
          default:           return 13'($urandom);
        endcase
      end
      SetNominal: begin
        case (idx)
          CFG_OVER_VOLTAGE:  return 13'd4200;
          CFG_UNDER_VOLTAGE: return 13'd3000;
          CFG_BALANCE_START: return 13'd3900;
          CFG_BALANCE_HYST:  return 13'd40;
          CFG_OVER_TEMP:     return 13'd65;
          CFG_UNDER_TEMP:    return 13'h00F6;
          CFG_CELL_GAP:      return 13'd200;
          default:           return 13'd100;
        endcase
      end
      default: return 13'($urandom);
    endcase
  endfunction

  task automatic send_tick(input in_t w);
    while (stalls_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(w);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [12:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
  endtask

  task automatic configure(input int kind);
    settle();
    for (int i = 0; i < NumCfgRegs; i++) begin
      write_reg(cfg_idx_e'(i), cfg_value(kind, cfg_idx_e'(i)));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int kinds[8];
    kinds = '{SetMax, SetMin, SetCrossed, SetRandom, SetNominal, SetRandom, SetRandom,
              SetRandom};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(mk(3700, 3650, 25, 20, 0, 0, 1, 0, 1, 0));
    send_tick(mk(8191, 0, 127, -128, 0, 0, 0, 0, 1, 0));
    send_tick(mk(0, 8191, -128, 127, 0, 0, 0, 0, 1, 0));
    send_tick(mk(4000, 3950, 30, 20, 1, 0, 0, 0, 1, 0));
    send_tick(mk(4000, 3950, 30, 20, 1, 0, 2, 0, 1, 0));
    send_tick(mk(4000, 3950, 30, 20, 1, 0, 255, 0, 1, 0));
    send_tick(mk(4000, 3950, 30, 20, 1, 0, 1, 0, 1, 0));
    send_tick(mk(4201, 3100, 66, -11, 1, 0, 1, 0, 1, 0));
    send_tick(mk(4200, 2999, 65, -10, 1, 0, 1, 1, 1, 0));
    send_tick(mk(3800, 3700, 60, -5, 1, 0, 1, 0, 1, 0));
    send_tick(mk(3800, 3700, 61, -6, 1, 1, 1, 0, 1, 0));
    send_tick(mk(3950, 3700, 20, 20, 1, 0, 0, 0, 1, 0));
    send_tick(mk(3950, 3700, 20, 20, 1, 0, 0, 0, 1, 0));
    send_tick(mk(3950, 3700, 20, 20, 1, 0, 1, 0, 1, 0));
    send_tick(mk(3950, 3700, 20, 20, 0, 0, 1, 0, 1, 0));
    send_tick(mk(3700, 3600, 20, 20, 0, 1, 1, 0, 1, 0));
    send_tick(mk(3700, 3600, 20, 20, 0, 1, 3, 0, 1, 0));
    send_tick(mk(3700, 3600, 20, 20, 0, 1, 1, 0, 1, 0));
    send_tick(mk(3700, 3600, 20, 20, 1, 0, 0, 1, 0, 0));
    send_tick(mk(3700, 3600, 20, 20, 0, 1, 1, 0, 1, 1));
    send_tick(mk(3700, 2999, 20, 20, 0, 0, 1, 0, 1, 0));
    send_tick(mk(3700, 3000, 20, 20, 0, 0, 1, 0, 0, 0));
    send_tick(mk(3700, 3000, 20, 20, 0, 0, 1, 0, 1, 1));
    send_tick(mk(3700, 3000, 20, 20, 0, 0, 1, 0, 1, 0));
    send_tick(mk(4100, 3000, 20, 20, 0, 0, 1, 0, 1, 1));

    foreach (kinds[p]) begin
      configure(kinds[p]);
      stalls_on = (p != 3);
      repeat (PhaseTicks) send_tick(rand_tick());
    end

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[battery_pack_supervisor_top.f]
sv/bps_pkg.sv
sv/battery_pack_supervisor_top.sv
verif/tb.sv
